### hdl/srp_pkg.sv
`default_nettype none

package srp_pkg;

  // Widths of the configuration port and of the request and result fields.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int DIM_W       = 14;
  localparam int RECT_W      = 10;
  localparam int PAD_W       = 8;
  localparam int SPAN_W      = 11;
  localparam int STATUS_W    = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PADDING      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] ATLAS_WIDTH_RST  = 14'd1024;
  localparam logic [DIM_W-1:0] ATLAS_HEIGHT_RST = 14'd1024;
  localparam logic [PAD_W-1:0] PADDING_RST      = 8'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                latch;
    logic                scan_start;
    logic                scan_step;
    logic                load_hit;
    logic                open_do;
    logic                place_do;
    logic                set_full;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic invalid;
    logic full;
    logic count_zero;
    logic hit;
    logic scan_last;
    logic table_full;
    logic open_low;
    logic fit_fail;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### hdl/srp_ctrl.sv
`default_nettype none

module srp_ctrl
  import srp_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_OPEN  = 3'd3;
  localparam logic [2:0] S_FIT   = 3'd4;
  localparam logic [2:0] S_PLACE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       second;
  logic       second_next;

  assign in_stall = (state != S_IDLE);

  // State and the flag that marks the second shelf opened for one request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next      = state;
    second_next     = second;
    cmd             = '0;
    cmd.res_status  = ST_PLACED;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        priority if (stat.invalid) begin
          cmd.res_status = ST_INVALID;
          if (stat.out_free) begin
            cmd.res_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (stat.full) begin
          cmd.res_status = ST_FULL;
          if (stat.out_free) begin
            cmd.res_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (stat.count_zero) begin
          second_next = 1'b0;
          state_next  = S_OPEN;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          cmd.load_hit = 1'b1;
          state_next   = S_FIT;
        end else if (stat.scan_last) begin
          second_next = 1'b0;
          state_next  = S_OPEN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_OPEN: begin
        priority if (stat.table_full) begin
          cmd.res_status = ST_TABLE;
          if (stat.out_free) begin
            cmd.res_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (stat.open_low) begin
          cmd.res_status = ST_FULL;
          if (stat.out_free) begin
            cmd.res_load = 1'b1;
            cmd.set_full = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.open_do = 1'b1;
          state_next  = second ? S_PLACE : S_FIT;
        end
      end
      S_FIT: begin
        if (stat.fit_fail) begin
          second_next = 1'b1;
          state_next  = S_OPEN;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        if (stat.out_free) begin
          cmd.place_do = 1'b1;
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/srp_datapath.sv
`default_nettype none

module srp_datapath
  import srp_pkg::*;
#(
  parameter int MAX_SHELF_COUNT = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  input  wire  [RECT_W-1:0]      rect_width,
  input  wire  [RECT_W-1:0]      rect_height,
  input  wire                    out_stall,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    status,
  output logic [DIM_W-1:0]       pos_x,
  output logic [DIM_W-1:0]       pos_y,
  input  wire  cmd_t             cmd,
  output stat_t                  stat
);

  localparam int IDX_W = (MAX_SHELF_COUNT > 1) ? $clog2(MAX_SHELF_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_SHELF_COUNT + 1);

  // Configuration registers.
  logic [DIM_W-1:0] atlas_width;
  logic [DIM_W-1:0] atlas_height;
  logic [PAD_W-1:0] padding;

  // Shelf table memories.
  logic [DIM_W-1:0]  top_mem    [MAX_SHELF_COUNT];
  logic [SPAN_W-1:0] span_mem   [MAX_SHELF_COUNT];
  logic [DIM_W-1:0]  cursor_mem [MAX_SHELF_COUNT];

  // Table bookkeeping and the full flag.
  logic [CNT_W-1:0] shelf_count;
  logic             atlas_full;
  logic [DIM_W:0]   base_y;

  // Request and scan registers.
  logic [SPAN_W-1:0] w_pad;
  logic [SPAN_W-1:0] h_pad;
  logic [IDX_W-1:0]  chk_idx;
  logic [DIM_W-1:0]  rd_top;
  logic [SPAN_W-1:0] rd_span;
  logic [DIM_W-1:0]  rd_cur;
  logic [IDX_W-1:0]  sel;
  logic [DIM_W-1:0]  sel_top;
  logic [DIM_W-1:0]  sel_cur;

  logic [IDX_W-1:0]  rd_addr;
  logic [SPAN_W:0]   h_max;
  logic [DIM_W+1:0]  new_y;
  logic [DIM_W+2:0]  new_bottom;
  logic              out_free;

  // Configuration writes; out-of-range indexes fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= ATLAS_WIDTH_RST;
      atlas_height <= ATLAS_HEIGHT_RST;
      padding      <= PADDING_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_ATLAS_WIDTH) begin
        atlas_width <= cfg_data;
      end
      if (cfg_index == REG_ATLAS_HEIGHT) begin
        atlas_height <= cfg_data;
      end
      if (cfg_index == REG_PADDING) begin
        padding <= cfg_data[PAD_W-1:0];
      end
    end
  end

  // Padded size of the accepted request.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      w_pad <= SPAN_W'(rect_width) + SPAN_W'(padding);
      h_pad <= SPAN_W'(rect_height) + SPAN_W'(padding);
    end
  end

  // Scan address: shelf zero on start, then the shelf after the one checked.
  assign rd_addr = cmd.scan_start ? '0 : IDX_W'(chk_idx + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.scan_step) begin
      chk_idx <= rd_addr;
      rd_top  <= top_mem[rd_addr];
      rd_span <= span_mem[rd_addr];
      rd_cur  <= cursor_mem[rd_addr];
    end
  end

  // Top and bottom of a shelf that would be opened below the last one.
  assign new_y      = (DIM_W+2)'(base_y) + (DIM_W+2)'(padding);
  assign new_bottom = (DIM_W+3)'(new_y) + (DIM_W+3)'(h_pad) + (DIM_W+3)'(padding);
  assign h_max      = (SPAN_W+1)'(h_pad) + (SPAN_W+1)'(h_pad >> 1);

  // Shelf table writes: a whole entry on open, the cursor on placement.
  always_ff @(posedge clk) begin
    if (cmd.open_do) begin
      top_mem[shelf_count[IDX_W-1:0]]  <= new_y[DIM_W-1:0];
      span_mem[shelf_count[IDX_W-1:0]] <= h_pad;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.open_do) begin
      cursor_mem[shelf_count[IDX_W-1:0]] <= DIM_W'(padding);
    end else if (cmd.place_do) begin
      cursor_mem[sel] <= sel_cur + DIM_W'(w_pad);
    end
  end

  // Table count, running bottom of the last shelf and the sticky full flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      shelf_count <= '0;
      base_y      <= '0;
      atlas_full  <= 1'b0;
    end else begin
      if (cmd.open_do) begin
        shelf_count <= shelf_count + 1'b1;
        base_y      <= (DIM_W+1)'(new_y[DIM_W-1:0]) + (DIM_W+1)'(h_pad);
      end
      if (cmd.set_full) begin
        atlas_full <= 1'b1;
      end
    end
  end

  // Selected shelf, either from a scan hit or freshly opened.
  always_ff @(posedge clk) begin
    if (cmd.load_hit) begin
      sel     <= chk_idx;
      sel_top <= rd_top;
      sel_cur <= rd_cur;
    end else if (cmd.open_do) begin
      sel     <= shelf_count[IDX_W-1:0];
      sel_top <= new_y[DIM_W-1:0];
      sel_cur <= DIM_W'(padding);
    end
  end

  // Result register.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= cmd.res_status;
      if (cmd.res_status == ST_PLACED) begin
        pos_x <= sel_cur;
        pos_y <= sel_top;
      end else begin
        pos_x <= '0;
        pos_y <= '0;
      end
    end
  end

  // Status flags for the controller.
  always_comb begin
    stat            = '0;
    stat.invalid    = (atlas_width == '0) || (atlas_height == '0);
    stat.full       = atlas_full;
    stat.count_zero = (shelf_count == '0);
    stat.hit        = (rd_span >= h_pad) && ((SPAN_W+1)'(rd_span) <= h_max) &&
                      ((DIM_W+1)'(rd_cur) + (DIM_W+1)'(padding) <=
                       (DIM_W+1)'(atlas_width));
    stat.scan_last  = ((CNT_W+1)'(chk_idx) + 1'b1) == (CNT_W+1)'(shelf_count);
    stat.table_full = (shelf_count == CNT_W'(MAX_SHELF_COUNT));
    stat.open_low   = new_bottom > (DIM_W+3)'(atlas_height);
    stat.fit_fail   = ((DIM_W+1)'(sel_cur) + (DIM_W+1)'(w_pad)) >
                      (DIM_W+1)'(atlas_width);
    stat.out_free   = out_free;
  end

endmodule

`default_nettype wire

### hdl/shelf_rectangle_packer.sv
`default_nettype none

// Shelf rectangle packer. Each request carries a rectangle size; the block pads it,
// places it on the first shelf of fitting height that still has room, opening new
// shelves below the last one as needed, and returns one result with a status and
// the placement's top-left corner. A request with an invalid atlas or the full flag set
// is answered without a search. Otherwise the shelf search reads one shelf per cycle
// through the registered read port of the shelf table; then a shelf is opened if
// needed, the fit is checked and the rectangle placed. A stalled output holds the
// request until the result register is free. One request is in flight at a time; a
// new request is taken while the previous result waits on the output. Configuration
// writes do not clear the shelves or the full flag; only reset does.
module shelf_rectangle_packer
  import srp_pkg::*;
#(
  parameter int MAX_SHELF_COUNT = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [RECT_W-1:0]      rect_width,
  input  wire  [RECT_W-1:0]      rect_height,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [DIM_W-1:0]       pos_x,
  output logic [DIM_W-1:0]       pos_y
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer for the search, shelf opening and placement.
  srp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Registers, shelf table and result register.
  srp_datapath #(
    .MAX_SHELF_COUNT (MAX_SHELF_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

### tb/tb_shelf_rectangle_packer.sv
module tb_shelf_rectangle_packer;
  import srp_pkg::*;

  localparam int SHELF_SLOTS = 32;
  // At or above this many open shelves the random mix aims at existing shelves.
  localparam int CROWDED = 28;
  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    x;
    logic [DIM_W-1:0]    y;
  } placement_t;

  typedef struct {
    bit                   is_write;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic [RECT_W-1:0]    rw;
    logic [RECT_W-1:0]    rh;
    bit                   typed;
    placement_t           want;
  } script_row_t;

  typedef enum logic {MIX_SHELVES, MIX_SPREAD} rect_mix_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [RECT_W-1:0]      rect_width = '0;
  logic [RECT_W-1:0]      rect_height = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [DIM_W-1:0]       pos_x;
  logic [DIM_W-1:0]       pos_y;

  shelf_rectangle_packer #(.MAX_SHELF_COUNT(SHELF_SLOTS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .rect_width(rect_width), .rect_height(rect_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .pos_x(pos_x), .pos_y(pos_y)
  );

  // Mirror of the packer state and registers.
  logic [DIM_W-1:0]  mirror_width = ATLAS_WIDTH_RST;
  logic [DIM_W-1:0]  mirror_height = ATLAS_HEIGHT_RST;
  logic [PAD_W-1:0]  mirror_pad = PADDING_RST;
  logic [DIM_W-1:0]  mirror_top [SHELF_SLOTS];
  logic [SPAN_W-1:0] mirror_span [SHELF_SLOTS];
  logic [DIM_W-1:0]  mirror_cursor [SHELF_SLOTS];
  int                shelf_cnt = 0;
  bit                mirror_full = 1'b0;

  placement_t  pending_placements [$];
  script_row_t script [$];
  int unsigned shelf_classes [6] = '{3, 8, 15, 30, 60, 120};

  bit idle_on = 1'b1;
  int bad_count = 0;
  int checked = 0;
  int sent = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("tb_shelf_rectangle_packer NOT OK");
    $finish;
  end

  // Opens a shelf of padded height span below the last one.
  function automatic logic [STATUS_W-1:0] open_shelf_pred(input int unsigned span,
                                                          output int idx);
    int unsigned y;
    int unsigned pad;
    idx = 0;
    pad = 32'(mirror_pad);
    if (shelf_cnt >= SHELF_SLOTS) return ST_TABLE;
    if (shelf_cnt == 0) y = pad;
    else y = 32'(mirror_top[shelf_cnt-1]) + 32'(mirror_span[shelf_cnt-1]) + pad;
    if (y + span + pad > 32'(mirror_height)) begin
      mirror_full = 1'b1;
      return ST_FULL;
    end
    mirror_top[shelf_cnt] = DIM_W'(y);
    mirror_span[shelf_cnt] = SPAN_W'(span);
    mirror_cursor[shelf_cnt] = DIM_W'(mirror_pad);
    idx = shelf_cnt;
    shelf_cnt++;
    return ST_PLACED;
  endfunction

  // Places one rectangle and returns the result the packer must give.
  function automatic placement_t place_rect(input logic [RECT_W-1:0] rw,
                                            input logic [RECT_W-1:0] rh);
    placement_t r;
    int unsigned w, h, s, c;
    int unsigned pad, aw, ah;
    int sel;
    bit found;
    logic [STATUS_W-1:0] st;
    r = '0;
    sel = 0;
    found = 1'b0;
    pad = 32'(mirror_pad);
    aw = 32'(mirror_width);
    ah = 32'(mirror_height);
    if (aw == 0 || ah == 0) begin
      r.status = ST_INVALID;
      return r;
    end
    if (mirror_full) begin
      r.status = ST_FULL;
      return r;
    end
    w = 32'(rw) + pad;
    h = 32'(rh) + pad;
    // First shelf of fitting height with its cursor still inside the atlas.
    for (int i = 0; i < shelf_cnt; i++) begin
      s = 32'(mirror_span[i]);
      c = 32'(mirror_cursor[i]);
      if (s >= h && s <= h + h / 2 && c + pad <= aw) begin
        sel = i;
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      st = open_shelf_pred(h, sel);
      if (st != ST_PLACED) begin
        r.status = st;
        return r;
      end
    end
    c = 32'(mirror_cursor[sel]);
    if (c + w > aw) begin
      st = open_shelf_pred(h, sel);
      if (st != ST_PLACED) begin
        r.status = st;
        return r;
      end
    end
    r.status = ST_PLACED;
    r.x = mirror_cursor[sel];
    r.y = mirror_top[sel];
    mirror_cursor[sel] = DIM_W'(32'(mirror_cursor[sel]) + w);
    return r;
  endfunction

  function automatic script_row_t wr(input logic [CFG_INDEX_W-1:0] idx, input int data);
    script_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.reg_index = idx;
    row.reg_data = CFG_DATA_W'(data);
    return row;
  endfunction

  function automatic script_row_t rq(input int rw, input int rh);
    script_row_t row;
    row = '{default: '0};
    row.rw = RECT_W'(rw);
    row.rh = RECT_W'(rh);
    return row;
  endfunction

  function automatic script_row_t rq_known(input int rw, input int rh,
                                           input logic [STATUS_W-1:0] st,
                                           input int x, input int y);
    script_row_t row;
    row = rq(rw, rh);
    row.typed = 1'b1;
    row.want.status = st;
    row.want.x = DIM_W'(x);
    row.want.y = DIM_W'(y);
    return row;
  endfunction

  // Waits until every result is back and the packer has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ATLAS_WIDTH: mirror_width = data;
      REG_ATLAS_HEIGHT: mirror_height = data;
      REG_PADDING: mirror_pad = data[PAD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drives one request and holds it until the packer takes it.
  task automatic send_rect(input logic [RECT_W-1:0] w, input logic [RECT_W-1:0] h);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rect_width <= w;
    rect_height <= h;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic run_phase(input int n, input bit idle, input rect_mix_t mix);
    logic [RECT_W-1:0] w, h;
    int r, k;
    int unsigned c;
    idle_on = idle;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (mix == MIX_SPREAD || r < 2) begin
        w = RECT_W'($urandom_range(0, 1023));
        h = (r < 50) ? RECT_W'($urandom_range(0, 255)) : RECT_W'($urandom_range(0, 1023));
      end else begin
        c = shelf_classes[$urandom_range(0, 5)];
        h = RECT_W'(c + $urandom_range(0, c / 8));
        w = (r < 8) ? RECT_W'($urandom_range(0, 1023)) : RECT_W'($urandom_range(0, 63));
        // With the table nearly used up, match an existing shelf exactly.
        if (shelf_cnt >= CROWDED) begin
          k = $urandom_range(0, shelf_cnt - 1);
          if (32'(mirror_span[k]) >= 32'(mirror_pad) &&
              32'(mirror_span[k]) - 32'(mirror_pad) <= 1023) begin
            h = RECT_W'(32'(mirror_span[k]) - 32'(mirror_pad));
            w = RECT_W'($urandom_range(0, 15));
          end
        end
      end
      pending_placements.push_back(place_rect(w, h));
      send_rect(w, h);
    end
  endtask

  // Receiver stalls in random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest pending placement.
  always @(posedge clk) begin
    placement_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got.status = status;
      got.x = pos_x;
      got.y = pos_y;
      if (pending_placements.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result: status %0d at (%0d,%0d)", got.status, got.x, got.y);
      end else begin
        want = pending_placements.pop_front();
        checked++;
        status_seen[want.status]++;
        if (got.status !== want.status || got.x !== want.x || got.y !== want.y) begin
          bad_count++;
          if (bad_count <= 10)
            $display("result %0d: expected status %0d at (%0d,%0d), got status %0d at (%0d,%0d)",
                     checked, want.status, want.x, want.y, got.status, got.x, got.y);
        end
      end
    end
  end

  initial begin
    placement_t p;
    int aim_full;
    int unsigned bottom;

    // Directed requests: extremes, invalid atlas, padding limits, overwide rectangles.
    script.push_back(rq_known(0, 0, ST_PLACED, 1, 1));
    script.push_back(rq_known(1, 0, ST_PLACED, 2, 1));
    script.push_back(wr(REG_ATLAS_HEIGHT, 8192));
    script.push_back(rq(1023, 1023));
    script.push_back(wr(REG_ATLAS_WIDTH, 0));
    script.push_back(rq_known(5, 5, ST_INVALID, 0, 0));
    script.push_back(wr(REG_ATLAS_WIDTH, 16383));
    script.push_back(wr(REG_ATLAS_HEIGHT, 0));
    script.push_back(rq_known(1023, 0, ST_INVALID, 0, 0));
    script.push_back(wr(REG_ATLAS_HEIGHT, 16383));
    script.push_back(wr(REG_PADDING, 0));
    script.push_back(rq(0, 0));
    script.push_back(rq(0, 1023));
    script.push_back(wr(REG_PADDING, 255));
    script.push_back(rq(512, 512));
    script.push_back(rq(1023, 1023));
    script.push_back(wr(REG_UNUSED, 16383));
    script.push_back(rq(7, 7));
    script.push_back(wr(REG_PADDING, 1));
    script.push_back(wr(REG_ATLAS_WIDTH, 16));
    script.push_back(rq(100, 3));
    script.push_back(rq(5, 3));
    script.push_back(wr(REG_ATLAS_WIDTH, 8192));
    script.push_back(rq(682, 341));
    script.push_back(rq(341, 682));
    script.push_back(rq(1, 1));
    script.push_back(rq(1, 1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_write) begin
        settle();
        set_reg(script[i].reg_index, script[i].reg_data);
      end else begin
        p = place_rect(script[i].rw, script[i].rh);
        if (script[i].typed) p = script[i].want;
        pending_placements.push_back(p);
        send_rect(script[i].rw, script[i].rh);
      end
    end

    // Random phases with shelf-friendly heights under several settings.
    settle();
    set_reg(REG_ATLAS_WIDTH, CFG_DATA_W'(8192));
    set_reg(REG_ATLAS_HEIGHT, CFG_DATA_W'(16383));
    set_reg(REG_PADDING, CFG_DATA_W'(1));
    run_phase(300, 1'b1, MIX_SHELVES);

    settle();
    set_reg(REG_PADDING, CFG_DATA_W'(0));
    set_reg(REG_ATLAS_WIDTH, CFG_DATA_W'(16383));
    run_phase(300, 1'b1, MIX_SHELVES);

    settle();
    set_reg(REG_PADDING, CFG_DATA_W'(255));
    set_reg(REG_ATLAS_WIDTH, CFG_DATA_W'(8192));
    run_phase(150, 1'b0, MIX_SHELVES);

    settle();
    set_reg(REG_PADDING, CFG_DATA_W'(2));
    set_reg(REG_ATLAS_WIDTH, CFG_DATA_W'(2048));
    run_phase(250, 1'b1, MIX_SHELVES);

    // Closing phase drives the packer either into a full atlas or out of shelves.
    settle();
    aim_full = $urandom_range(0, 1);
    if (aim_full != 0) begin
      if (shelf_cnt == 0) bottom = 32'(mirror_pad);
      else bottom = 32'(mirror_top[shelf_cnt-1]) + 32'(mirror_span[shelf_cnt-1]) +
                    32'(mirror_pad);
      bottom = bottom + 300;
      if (bottom > 16383) bottom = 16383;
      set_reg(REG_ATLAS_HEIGHT, CFG_DATA_W'(bottom));
    end else begin
      set_reg(REG_ATLAS_WIDTH, CFG_DATA_W'(512));
      set_reg(REG_PADDING, CFG_DATA_W'(0));
      set_reg(REG_ATLAS_HEIGHT, CFG_DATA_W'(16383));
    end
    run_phase(180, 1'b0, MIX_SPREAD);

    // Invalid atlas takes priority over a full one.
    settle();
    set_reg(REG_ATLAS_WIDTH, CFG_DATA_W'(0));
    run_phase(8, 1'b0, MIX_SPREAD);

    settle();
    repeat (48) @(posedge clk);
    bad_count += pending_placements.size();

    $display("%0d rectangles requested, %0d results compared, %0d shelves open at the end",
             sent, checked, shelf_cnt);
    $display("status mix: placed %0d, atlas full %0d, table exhausted %0d, invalid %0d",
             status_seen[ST_PLACED], status_seen[ST_FULL], status_seen[ST_TABLE],
             status_seen[ST_INVALID]);
    if (bad_count == 0) begin
      $display("tb_shelf_rectangle_packer OK");
    end else begin
      $display("tb_shelf_rectangle_packer NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hdl/srp_pkg.sv
hdl/srp_ctrl.sv
hdl/srp_datapath.sv
hdl/shelf_rectangle_packer.sv
tb/tb_shelf_rectangle_packer.sv
